@@ hw/rtl/variable_range_memtype_table_assert.svh @@
// Assertion macros shared by the range table RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef VARIABLE_RANGE_MEMTYPE_TABLE_ASSERT_SVH
`define VARIABLE_RANGE_MEMTYPE_TABLE_ASSERT_SVH

// Same-cycle implication
`define VRMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vrmt_pkg.sv @@
`default_nettype none

package vrmt_pkg;

    // Table geometry
    localparam int unsigned MAX_SLOTS_DEF = 8;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned PAGE_LSB      = 12;
    localparam int unsigned PAGE_W        = ADDR_W - PAGE_LSB;
    localparam int unsigned MTYPE_W       = 8;

    // Operation modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CLAIM = 2'd0;
    localparam t_mode MODE_QUERY = 2'd1;
    localparam t_mode MODE_RAW   = 2'd2;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_UNSUP    = 3'd1;
    localparam t_status ST_NO_WC    = 3'd2;
    localparam t_status ST_NO_SLOT  = 3'd3;
    localparam t_status ST_DISABLED = 3'd4;
    localparam t_status ST_BAD_SLOT = 3'd5;

    // Memory types
    localparam logic [MTYPE_W-1:0] TYPE_UC = 8'h00;
    localparam logic [MTYPE_W-1:0] TYPE_WC = 8'h01;
    localparam logic [MTYPE_W-1:0] TYPE_WT = 8'h04;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WC_CAPABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_RESET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT    = 3'd4;

    // One stored range
    typedef struct packed {
        logic [MTYPE_W-1:0] mtype;
        logic [PAGE_W-1:0]  mask_page;
        logic [PAGE_W-1:0]  base_page;
    } t_entry;

    // Running resolution of a query walk
    typedef struct packed {
        logic               found;
        logic [MTYPE_W-1:0] eff;
    } t_acc;

endpackage

`default_nettype wire

@@ hw/rtl/vrmt_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module vrmt_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/vrmt_match.sv @@
`default_nettype none

// Slot match and type merge: one slot per use, shared across the walk
module vrmt_match (
    input  wire logic [vrmt_pkg::PAGE_W-1:0] i_apage,
    input  wire logic                        i_slot_vld,
    input  wire vrmt_pkg::t_entry            i_entry,
    input  wire vrmt_pkg::t_acc              i_acc,
    output vrmt_pkg::t_acc                   o_acc
);

    logic hit;

    // masked page compare
    assign hit = i_slot_vld &&
        ((i_apage & i_entry.mask_page) == (i_entry.base_page & i_entry.mask_page));

    // UC beats everything, then WT, otherwise first hit stands
    always_comb begin
        o_acc = i_acc;
        if (hit) begin
            if (!i_acc.found) begin
                o_acc.found = 1'b1;
                o_acc.eff   = i_entry.mtype;
            end else if (i_entry.mtype == vrmt_pkg::TYPE_UC ||
                         i_acc.eff == vrmt_pkg::TYPE_UC) begin
                o_acc.eff = vrmt_pkg::TYPE_UC;
            end else if (i_entry.mtype == vrmt_pkg::TYPE_WT ||
                         i_acc.eff == vrmt_pkg::TYPE_WT) begin
                o_acc.eff = vrmt_pkg::TYPE_WT;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/variable_range_memtype_table.sv @@
`default_nettype none

// Variable memory-type range table. Mode 0 rounds the region size up to a
// power of two, aligns the base down and claims the first free slot as a
// write-combining range; mode 1 resolves the effective memory type of an
// address; mode 2 writes one slot directly. Only one word is in flight: the
// input stalls from accept until the result is loaded into the output
// register. A query walks the active slots one per cycle through the slot
// RAM read port and the shared match unit; a claim walks only up to the
// first free slot; a raw write or a word answered by status alone goes
// straight to the result. A waiting result does not block the next accept
// until the next result is due. Configuration writes are taken at any time
// but should only be issued while no word is in flight.
`include "variable_range_memtype_table_assert.svh"

module variable_range_memtype_table #(
    parameter int unsigned MAX_SLOTS = vrmt_pkg::MAX_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [vrmt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [vrmt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_region_bytes,
    input  wire logic [2:0]  i_slot_index,
    input  wire logic [7:0]  i_type_code,
    input  wire logic [19:0] i_mask_page_bits,
    input  wire logic        i_valid_bit,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [2:0]       o_slot_used,
    output logic [7:0]       o_effective_type,
    output logic [31:0]      o_range_base,
    output logic [31:0]      o_rounded_size
);

    localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int unsigned CW    = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // round up to a power of two; zero rounds to one, above 2^31 wraps to zero
    function automatic logic [31:0] round_pow2(input logic [31:0] v);
        logic [31:0] t;
        begin
            t = v - 32'd1;
            t = t | (t >> 1);
            t = t | (t >> 2);
            t = t | (t >> 4);
            t = t | (t >> 8);
            t = t | (t >> 16);
            round_pow2 = (v == 32'd0) ? 32'd1 : t + 32'd1;
        end
    endfunction

    // control state
    t_state               r_state;
    logic [MAX_SLOTS-1:0] r_valid;
    logic                 r_forced_on;
    logic                 r_out_vld;
    logic                 r_feature;
    logic [3:0]           r_slot_count;
    logic                 r_wc;
    logic                 r_en_reset;
    logic [7:0]           r_default_type;

    // latched word and working registers
    vrmt_pkg::t_mode      r_mode;
    logic [31:0]          r_addr;
    logic [31:0]          r_bytes;
    logic [2:0]           r_sidx;
    logic [7:0]           r_tcode;
    logic [19:0]          r_mbits;
    logic                 r_vbit;
    logic [31:0]          r_rsize;
    logic [IDX_W-1:0]     r_idx;
    vrmt_pkg::t_acc       r_acc;
    vrmt_pkg::t_status    r_status;
    logic [2:0]           r_used;

    // output register
    vrmt_pkg::t_status    r_out_status;
    logic [2:0]           r_out_used;
    logic [7:0]           r_out_eff;
    logic [31:0]          r_out_abase;
    logic [31:0]          r_out_rsize;

    logic [CW-1:0]        sc_ext;
    logic [CW-1:0]        n_act;
    logic                 supported;
    logic                 idx_last;
    logic                 bad_slot;
    logic                 slot_free;
    logic                 claim_take;
    logic                 raw_prep;
    logic                 out_free;
    logic                 accept;
    logic [31:0]          size_mask;
    logic [31:0]          abase;
    logic [7:0]           query_eff;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    vrmt_pkg::t_entry     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    vrmt_pkg::t_entry     ram_rdata;
    vrmt_pkg::t_acc       acc_next;

    // active slot count, saturated to the table size
    assign sc_ext    = CW'(r_slot_count);
    assign n_act     = (sc_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : sc_ext;
    assign supported = r_feature && (n_act != '0);
    assign idx_last  = ((CW'(r_idx) + CW'(1)) == n_act);
    assign bad_slot  = (CW'(r_sidx) >= n_act);
    assign slot_free = !r_valid[r_idx];

    // claim hit during the walk, raw write in PREP
    assign claim_take = (r_state == S_WALK) && (r_mode == vrmt_pkg::MODE_CLAIM) && slot_free;
    assign raw_prep   = (r_state == S_PREP) && (r_mode == vrmt_pkg::MODE_RAW);

    // handshakes
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // alignment from the registered rounded size
    assign size_mask = ~(r_rsize - 32'd1);
    assign abase     = r_addr & size_mask;
    assign query_eff = r_acc.found ? r_acc.eff : r_default_type;

    // slot RAM ports: raw write in PREP, claim write during the walk
    assign ram_we    = (raw_prep && !bad_slot) || claim_take;
    assign ram_waddr = (r_state == S_PREP) ? IDX_W'(r_sidx) : r_idx;

    always_comb begin
        if (r_state == S_PREP) begin
            ram_wdata.mtype     = r_tcode;
            ram_wdata.mask_page = r_mbits;
            ram_wdata.base_page = r_addr[31:vrmt_pkg::PAGE_LSB];
        end else begin
            ram_wdata.mtype     = vrmt_pkg::TYPE_WC;
            ram_wdata.mask_page = size_mask[31:vrmt_pkg::PAGE_LSB];
            ram_wdata.base_page = abase[31:vrmt_pkg::PAGE_LSB];
        end
    end

    // query reads run one slot ahead of the compare
    assign ram_re = (r_mode == vrmt_pkg::MODE_QUERY) &&
                    ((r_state == S_PREP) || (r_state == S_WALK && !idx_last));
    assign ram_raddr = (r_state == S_PREP) ? '0 : r_idx + IDX_W'(1);

    vrmt_ram #(
        .WIDTH ($bits(vrmt_pkg::t_entry)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vrmt_match u_match (
        .i_apage    (r_addr[31:vrmt_pkg::PAGE_LSB]),
        .i_slot_vld (r_valid[r_idx]),
        .i_entry    (ram_rdata),
        .i_acc      (r_acc),
        .o_acc      (acc_next)
    );

    // sequencer, valid bits, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_valid        <= '0;
            r_forced_on    <= 1'b0;
            r_out_vld      <= 1'b0;
            r_feature      <= 1'b1;
            r_slot_count   <= 4'd8;
            r_wc           <= 1'b1;
            r_en_reset     <= 1'b0;
            r_default_type <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vrmt_pkg::CFG_FEATURE:    r_feature      <= i_cfg_data[0];
                    vrmt_pkg::CFG_SLOT_COUNT: r_slot_count   <= i_cfg_data[3:0];
                    vrmt_pkg::CFG_WC_CAPABLE: r_wc           <= i_cfg_data[0];
                    vrmt_pkg::CFG_EN_RESET:   r_en_reset     <= i_cfg_data[0];
                    vrmt_pkg::CFG_DEFAULT:    r_default_type <= i_cfg_data;
                    default: ;
                endcase
            end

            // output word: load from DONE, drop once taken
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    case (r_mode)
                        vrmt_pkg::MODE_CLAIM: begin
                            r_state <= (supported && r_wc) ? S_WALK : S_DONE;
                        end
                        vrmt_pkg::MODE_QUERY: begin
                            r_state <= (supported && (r_en_reset || r_forced_on)) ?
                                       S_WALK : S_DONE;
                        end
                        vrmt_pkg::MODE_RAW: begin
                            if (!bad_slot) begin
                                r_valid[IDX_W'(r_sidx)] <= r_vbit;
                            end
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_WALK: begin
                    if (r_mode == vrmt_pkg::MODE_CLAIM && slot_free) begin
                        r_valid[r_idx] <= 1'b1;
                        r_forced_on    <= 1'b1;
                        r_state        <= S_DONE;
                    end else if (idx_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_mode  <= i_mode;
                    r_addr  <= i_address;
                    r_bytes <= i_region_bytes;
                    r_sidx  <= i_slot_index;
                    r_tcode <= i_type_code;
                    r_mbits <= i_mask_page_bits;
                    r_vbit  <= i_valid_bit;
                end
            end
            S_PREP: begin
                r_rsize <= round_pow2(r_bytes);
                r_idx   <= '0;
                r_acc   <= '0;
                r_used  <= (r_mode == vrmt_pkg::MODE_RAW && !bad_slot) ? r_sidx : 3'd0;
                case (r_mode)
                    vrmt_pkg::MODE_CLAIM: begin
                        r_status <= !supported ? vrmt_pkg::ST_UNSUP :
                                    !r_wc      ? vrmt_pkg::ST_NO_WC :
                                                 vrmt_pkg::ST_NO_SLOT;
                    end
                    vrmt_pkg::MODE_QUERY: begin
                        r_status <= !supported                   ? vrmt_pkg::ST_UNSUP :
                                    !(r_en_reset || r_forced_on) ? vrmt_pkg::ST_DISABLED :
                                                                   vrmt_pkg::ST_OK;
                    end
                    vrmt_pkg::MODE_RAW: begin
                        r_status <= bad_slot ? vrmt_pkg::ST_BAD_SLOT : vrmt_pkg::ST_OK;
                    end
                    default: r_status <= vrmt_pkg::ST_UNSUP;
                endcase
            end
            S_WALK: begin
                r_idx <= r_idx + IDX_W'(1);
                if (r_mode == vrmt_pkg::MODE_CLAIM) begin
                    if (slot_free) begin
                        r_status <= vrmt_pkg::ST_OK;
                        r_used   <= 3'(r_idx);
                    end
                end else begin
                    r_acc <= acc_next;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_used   <= r_used;
                    r_out_eff    <= (r_mode == vrmt_pkg::MODE_QUERY &&
                                     r_status == vrmt_pkg::ST_OK) ? query_eff : 8'h00;
                    r_out_abase  <= (r_mode == vrmt_pkg::MODE_CLAIM) ? abase : 32'd0;
                    r_out_rsize  <= (r_mode == vrmt_pkg::MODE_CLAIM) ? r_rsize : 32'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_out_vld;
    assign o_status         = r_out_status;
    assign o_slot_used      = r_out_used;
    assign o_effective_type = r_out_eff;
    assign o_range_base     = r_out_abase;
    assign o_rounded_size   = r_out_rsize;

    // checks
    `VRMT_ASSERT_NEXT(a_accept_to_prep, accept, r_state == S_PREP, "accept did not enter PREP")
    `VRMT_ASSERT_NEXT(a_out_in_done, !r_out_vld && (r_state != S_DONE), !r_out_vld, "early result")
    `VRMT_ASSERT_NEXT(a_claim_enables, claim_take, r_forced_on, "claim left ranges disabled")
    `VRMT_ASSERT_NEXT(a_bad_slot, raw_prep && bad_slot, $stable(r_valid), "bad slot changed valid")

endmodule

`default_nettype wire
